[hw/rtl/slr_pkg.sv]
// Constants, state encoding and modular arithmetic for the subtractive lagged generator.
package slr_pkg;

	localparam int VALUE_W = 30;
	localparam int SEED_W = 32;
	localparam int LONG_LAG_DEF = 55;
	localparam int SHORT_LAG_DEF = 24;
	localparam int SPREAD = 21;
	localparam int WARMUP_ROUNDS = 5;
	localparam logic [VALUE_W-1:0] MODULUS = 30'd1000000000;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAW,
		ST_REDUCE,
		ST_FILL,
		ST_WARM_RD,
		ST_WARM_WR
	} slr_state_t;

	// (a - b) mod 10^9 for a, b below the modulus
	function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic [VALUE_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[VALUE_W]) begin
			d = d + {1'b0, MODULUS};
		end
		return d[VALUE_W-1:0];
	endfunction

endpackage

[hw/rtl/subtractive_lagged_random.sv]
// Top level of the subtractive lagged generator: sequencer, index logic and table.
//
// Draw requests (kind = 0) return (X[n-LONG_LAG] - X[n-SHORT_LAG]) mod 10^9 on value,
// marked by strobe for one cycle once the draw has passed ST_DRAW and the value register;
// busy is high in ST_DRAW, so the next request is taken only back in ST_IDLE. The table
// read is registered and the new entry is written back in the cycle after it. A reseed
// request (kind = 1) gives no result and holds busy through seed reduction (ST_REDUCE),
// the table fill (ST_FILL) and WARMUP_ROUNDS * LONG_LAG warm-up draws. After reset the
// block first zeroes the table (ST_CLEAR) and then seeds itself with zero, so busy stays
// high through the clear, the fill and the warm-up. The receiver cannot stall: each
// result is presented once.
module subtractive_lagged_random
	import slr_pkg::*;
#(
	parameter int LONG_LAG = LONG_LAG_DEF,
	parameter int SHORT_LAG = SHORT_LAG_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     kind,
	input  logic signed [SEED_W-1:0] seed,
	output logic                     strobe,
	output logic [VALUE_W-1:0]       value
);

	localparam int IDX_W = $clog2(LONG_LAG);
	localparam int LAG_START = (LONG_LAG - SHORT_LAG % LONG_LAG) % LONG_LAG;
	localparam int STEP = SPREAD % LONG_LAG;
	localparam int WARM_DRAWS = WARMUP_ROUNDS * LONG_LAG;
	localparam int CNT_W = $clog2(WARM_DRAWS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LONG_LAG - 1);

	slr_state_t state_q, state_next;

	logic [IDX_W-1:0]   head_q, lag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   wa_q;
	logic [SEED_W-1:0]  mag_q;
	logic [VALUE_W-1:0] prev_q, cur_q;
	logic [VALUE_W-1:0] value_q;
	logic               strobe_q;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic [VALUE_W-1:0] rd_head, rd_lag;
	logic [VALUE_W-1:0] draw_val;
	logic [VALUE_W-1:0] fill_next;
	logic [IDX_W:0]     wa_sum;
	logic [IDX_W-1:0]   wa_next;
	logic [IDX_W-1:0]   head_next, lag_next;
	logic               accept, cnt_lag_last, cnt_warm_last, mag_ge;

	assign accept        = start && !busy;
	assign cnt_lag_last  = (cnt_q == CNT_W'(LONG_LAG - 1));
	assign cnt_warm_last = (cnt_q == CNT_W'(WARM_DRAWS - 1));
	assign mag_ge        = (mag_q >= {{(SEED_W - VALUE_W){1'b0}}, MODULUS});

	assign draw_val  = sub_mod(rd_head, rd_lag);
	assign fill_next = sub_mod(prev_q, cur_q);
	assign wa_sum    = {1'b0, wa_q} + (IDX_W + 1)'(STEP);
	assign wa_next   = (wa_sum >= (IDX_W + 1)'(LONG_LAG)) ?
		IDX_W'(wa_sum - (IDX_W + 1)'(LONG_LAG)) : wa_sum[IDX_W-1:0];
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign lag_next  = (lag_q == LAST_IDX) ? '0 : lag_q + 1'b1;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR:   if (cnt_lag_last) state_next = ST_REDUCE;
			ST_IDLE: begin
				if (accept) begin
					state_next = kind ? ST_REDUCE : ST_DRAW;
				end
			end
			ST_DRAW:    state_next = ST_IDLE;
			ST_REDUCE:  if (!mag_ge) state_next = ST_FILL;
			ST_FILL:    if (cnt_lag_last) state_next = ST_WARM_RD;
			ST_WARM_RD: state_next = ST_WARM_WR;
			ST_WARM_WR: state_next = cnt_warm_last ? ST_IDLE : ST_WARM_RD;
			default:    state_next = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy    = 1'b1;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = draw_val;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[IDX_W-1:0];
				wr_data = '0;
			end
			ST_IDLE:    busy = 1'b0;
			ST_DRAW:    wr_en = 1'b1;
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_addr = wa_q;
				wr_data = (cnt_q == '0) ? prev_q : cur_q;
			end
			ST_WARM_WR: wr_en = 1'b1;
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cnt_q    <= '0;
			head_q   <= '0;
			lag_q    <= IDX_W'(LAG_START);
			mag_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_next;
			strobe_q <= (state_q == ST_DRAW);
			case (state_q)
				ST_CLEAR:   cnt_q <= cnt_lag_last ? '0 : cnt_q + 1'b1;
				ST_IDLE: begin
					if (accept && kind) begin
						mag_q <= seed[SEED_W-1] ? (SEED_W'(0) - $unsigned(seed)) :
							$unsigned(seed);
					end
				end
				ST_DRAW: begin
					head_q <= head_next;
					lag_q  <= lag_next;
				end
				ST_REDUCE: begin
					if (mag_ge) begin
						mag_q <= mag_q - {{(SEED_W - VALUE_W){1'b0}}, MODULUS};
					end else begin
						cnt_q <= '0;
					end
				end
				ST_FILL: begin
					if (cnt_lag_last) begin
						cnt_q  <= '0;
						head_q <= '0;
						lag_q  <= IDX_W'(LAG_START);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WARM_WR: begin
					head_q <= head_next;
					lag_q  <= lag_next;
					cnt_q  <= cnt_warm_last ? '0 : cnt_q + 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW) begin
			value_q <= draw_val;
		end
		if (state_q == ST_REDUCE && !mag_ge) begin
			prev_q <= mag_q[VALUE_W-1:0];
			cur_q  <= VALUE_W'(1);
			wa_q   <= '0;
		end
		if (state_q == ST_FILL) begin
			wa_q <= wa_next;
			// the seed itself goes in first; advance the difference chain after that
			if (cnt_q != '0) begin
				prev_q <= cur_q;
				cur_q  <= fill_next;
			end
		end
	end

	slr_ram #(
		.DEPTH(LONG_LAG),
		.WIDTH(VALUE_W)
	) u_table (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (head_q),
		.raddr_b (lag_q),
		.rdata_a (rd_head),
		.rdata_b (rd_lag)
	);

	assign strobe = strobe_q;
	assign value  = value_q;

	a_draw_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !kind) |=> ##1 strobe)
		else $error("draw request gave no result");

	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_DRAW))
		else $error("result strobe without a draw");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (value < MODULUS))
		else $error("result not below the modulus");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (state_q == ST_DRAW || state_q == ST_WARM_WR)) |-> (draw_val < MODULUS))
		else $error("table entry not below the modulus");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= LAST_IDX) && (lag_q <= LAST_IDX))
		else $error("table index out of range");

endmodule

[hw/rtl/slr_ram.sv]
// History table: one write port, two read ports with registered read data.
module slr_ram
	import slr_pkg::*;
#(
	parameter int DEPTH = LONG_LAG_DEF,
	parameter int WIDTH = VALUE_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[dv/tb_top.sv]
// Testbench for the subtractive lagged generator: predicts draws and reseeds, checks every value.
module tb_top;
	import slr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MOD_U = MODULUS;
	localparam int LONG_LAG = LONG_LAG_DEF;
	localparam int SHORT_LAG = SHORT_LAG_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 650;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     kind;
	logic signed [SEED_W-1:0] seed;
	logic                     strobe;
	logic [VALUE_W-1:0]       value;

	int unsigned rng_table [LONG_LAG];
	int unsigned head_ptr;
	int unsigned lag_ptr;
	logic [VALUE_W-1:0] pending_values [$];
	int error_count = 0;
	int idle_cycles = 0;
	bit steady_flow = 0;

	subtractive_lagged_random dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.seed(seed),
		.strobe(strobe),
		.value(value)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int unsigned diff_mod(input int unsigned a, input int unsigned b);
		return (a >= b) ? (a - b) : (a + MOD_U - b);
	endfunction

	function automatic int unsigned lag_origin();
		int unsigned off;
		off = SHORT_LAG % LONG_LAG;
		return (LONG_LAG - off) % LONG_LAG;
	endfunction

	function automatic int unsigned next_value();
		int unsigned r;
		r = diff_mod(rng_table[head_ptr], rng_table[lag_ptr]);
		rng_table[head_ptr] = r;
		head_ptr = (head_ptr + 1) % LONG_LAG;
		lag_ptr = (lag_ptr + 1) % LONG_LAG;
		return r;
	endfunction

	function automatic void seed_table(input logic [SEED_W-1:0] raw);
		logic [SEED_W-1:0] mag;
		int unsigned prev;
		int unsigned cur;
		int unsigned nxt;
		int unsigned idx;
		mag = raw[SEED_W-1] ? (32'd0 - raw) : raw;
		prev = mag % MOD_U;
		cur = 1;
		rng_table[0] = prev;
		for (int i = 1; i < LONG_LAG; i++) begin
			idx = (SPREAD * i) % LONG_LAG;
			nxt = diff_mod(prev, cur);
			rng_table[idx] = cur;
			prev = cur;
			cur = nxt;
		end
		head_ptr = 0;
		lag_ptr = lag_origin();
		repeat (WARMUP_ROUNDS * LONG_LAG) void'(next_value());
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic k, input logic signed [SEED_W-1:0] s);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			kind <= 1'($urandom);
			seed <= $urandom;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		seed <= s;
		do @(posedge clk); while (busy);
		if (k) begin
			seed_table(s);
		end else begin
			pending_values.push_back(VALUE_W'(next_value()));
		end
		@(negedge clk);
	endtask

	// Result check: each strobe pops the oldest predicted value.
	always @(posedge clk) begin
		logic [VALUE_W-1:0] exp_value;
		if (arst_n && strobe) begin
			if (pending_values.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d", value));
			end else begin
				exp_value = pending_values.pop_front();
				if (value !== exp_value) begin
					report_mismatch($sformatf("value=%0d expected %0d", value, exp_value));
				end
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((start && !busy) || strobe)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("tb_top failed");
		$finish;
	end

	task automatic test_reset_seed();
		repeat (3) send_request(1'b0, $urandom);
	endtask

	task automatic test_seed_extremes();
		logic signed [SEED_W-1:0] seeds [7];
		seeds = '{32'sd0, 32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 32'sd1000000000,
			32'sd999999999, -32'sd2147483647};
		foreach (seeds[i]) begin
			send_request(1'b1, seeds[i]);
			repeat (2) send_request(1'b0, $urandom);
		end
	endtask

	task automatic test_back_to_back_reseed();
		send_request(1'b1, 32'sd12345);
		send_request(1'b1, -32'sd54321);
		send_request(1'b0, 32'sd0);
	endtask

	task automatic test_random_traffic();
		logic signed [SEED_W-1:0] s;
		for (int n = 0; n < 520; n++) begin
			// alternate stretches of back-to-back requests with randomly gapped ones
			if (n % 90 == 0) begin
				steady_flow = ($urandom_range(0, 2) == 0);
			end
			if ($urandom_range(0, 39) == 0) begin
				case ($urandom_range(0, 3))
					0: s = $urandom;
					1: s = $urandom_range(0, 2000);
					2: s = -$signed(32'($urandom_range(0, 2000)));
					default: s = {1'b1, 31'($urandom)};
				endcase
				send_request(1'b1, s);
			end else begin
				send_request(1'b0, $urandom);
			end
		end
		steady_flow = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = 1'b0;
		seed = '0;
		foreach (rng_table[i]) rng_table[i] = 0;
		head_ptr = 0;
		lag_ptr = lag_origin();
		seed_table('0);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_seed();
		test_seed_extremes();
		test_back_to_back_reseed();
		test_random_traffic();
		send_request(1'b0, $urandom);

		start <= 1'b0;
		while (pending_values.size() != 0) @(posedge clk);
		// hold off long enough for a trailing reseed to finish and catch stray strobes
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
